[src/etvf_pkg.sv]
`timescale 1ns / 1ps

package etvf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] RESPONSE_TIME_RESET = DATA_W'(160);

    localparam logic [1:0] OP_LOAD       = 2'd0;
    localparam logic [1:0] OP_SET_TARGET = 2'd1;
    localparam logic [1:0] OP_UPDATE     = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value_in;
        logic [DATA_W-1:0]        now;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] current_value;
        logic                     ready_res;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic eval;
        logic mul;
        logic div_step;
        logic apply;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_status;

endpackage

[src/elapsed_time_value_follower.sv]
`timescale 1ns / 1ps
// Flow: the input item is latched and evaluated; load, set target and updates that jump
// or hold then go to finish, while updates that step first run multiply, 32 restoring
// division steps and clamp. One item at a time; finish waits while a result is unread.
// Reset (synchronous, active low): value, target and last time cleared, not initialised,
// response time 160; a finished result may wait in the output register during the next item.

module elapsed_time_value_follower (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [etvf_pkg::DATA_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  etvf_pkg::t_in_item          i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output etvf_pkg::t_out_item         o_item
);
    import etvf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    etvf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    etvf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (i_item),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_item        (o_item)
    );

endmodule

[src/etvf_ctrl.sv]
`timescale 1ns / 1ps

module etvf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output etvf_pkg::t_cmd  o_cmd,
    input  etvf_pkg::t_status i_status
);
    import etvf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             w_accept;
    logic             w_div_last;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = w_accept;
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.load_out = (r_state == S_FINISH) && (!r_valid || i_ready);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_status.need_div ? S_MUL : S_FINISH;
            end
            S_MUL: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                if (w_div_last) begin
                    n_state = S_APPLY;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_APPLY: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (o_cmd.load_out) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("transfer accepted while an item is in progress");

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finish");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_last) |=> (r_state == S_APPLY))
        else $error("division did not complete after its last step");

    a_cnt_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_state == S_DIV))
        else $error("step counter running outside division");

endmodule

[src/etvf_dp.sv]
`timescale 1ns / 1ps

module etvf_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [etvf_pkg::DATA_W-1:0] i_cfg_wr_data,
    input  etvf_pkg::t_in_item          i_item,
    input  etvf_pkg::t_cmd              i_cmd,
    output etvf_pkg::t_status           o_status,
    output etvf_pkg::t_out_item         o_item
);
    import etvf_pkg::*;

    logic [DATA_W-1:0]        r_resp;
    logic signed [DATA_W-1:0] r_follow, n_follow;
    logic signed [DATA_W-1:0] r_goal, n_goal;
    logic [DATA_W-1:0]        r_last, n_last;
    logic                     r_init, n_init;

    t_in_item                 r_item;
    logic                     r_uninit, n_uninit;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_absd;
    logic [DATA_W-1:0]        r_elapsed;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_quo;
    t_out_item                r_out;

    logic [DATA_W-1:0]        w_elapsed;
    logic signed [DATA_W:0]   w_delta;
    logic [DATA_W:0]          w_absd;
    logic [2*DATA_W-1:0]      w_prod;
    logic [DATA_W:0]          w_trial;
    logic                     w_qbit;
    logic [DATA_W:0]          w_mag;
    logic signed [DATA_W:0]   w_sum;
    logic signed [DATA_W:0]   w_goal_x;
    logic                     w_need_div;

    assign w_elapsed = r_item.now - r_last;
    assign w_delta   = {r_goal[DATA_W-1], r_goal} - {r_follow[DATA_W-1], r_follow};
    assign w_absd    = w_delta[DATA_W] ? (-w_delta) : w_delta;
    assign w_prod    = r_absd * r_elapsed;
    assign w_trial   = {r_rem, r_quo[DATA_W-1]};
    assign w_qbit    = (w_trial >= {1'b0, r_resp});
    assign w_mag     = (r_quo == '0) ? (DATA_W+1)'(1) : {1'b0, r_quo};
    assign w_goal_x  = {r_goal[DATA_W-1], r_goal};
    assign w_sum     = r_neg ? ({r_follow[DATA_W-1], r_follow} - $signed(w_mag))
                             : ({r_follow[DATA_W-1], r_follow} + $signed(w_mag));

    always_comb begin
        n_follow   = r_follow;
        n_goal     = r_goal;
        n_last     = r_last;
        n_init     = r_init;
        n_uninit   = r_uninit;
        w_need_div = 1'b0;
        if (i_cmd.eval) begin
            n_uninit = 1'b0;
            unique case (r_item.operation)
                OP_LOAD: begin
                    n_follow = r_item.value_in;
                    n_goal   = r_item.value_in;
                    n_last   = r_item.now;
                    n_init   = 1'b1;
                end
                OP_SET_TARGET: begin
                    if (!r_init) begin
                        n_follow = r_item.value_in;
                        n_last   = r_item.now;
                        n_init   = 1'b1;
                    end
                    n_goal = r_item.value_in;
                end
                OP_UPDATE: begin
                    if (!r_init) begin
                        n_uninit = 1'b1;
                    end else begin
                        n_last = r_item.now;
                        if (w_delta != '0 && w_elapsed != '0) begin
                            if (r_resp == '0 || w_elapsed >= r_resp) begin
                                n_follow = r_goal;
                            end else begin
                                w_need_div = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.apply) begin
            if (r_neg ? (w_sum < w_goal_x) : (w_sum > w_goal_x)) begin
                n_follow = r_goal;
            end else begin
                n_follow = w_sum[DATA_W-1:0];
            end
        end
    end

    assign o_status.need_div = w_need_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp   <= RESPONSE_TIME_RESET;
            r_follow <= '0;
            r_goal   <= '0;
            r_last   <= '0;
            r_init   <= 1'b0;
            r_uninit <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_resp <= i_cfg_wr_data;
            end
            r_follow <= n_follow;
            r_goal   <= n_goal;
            r_last   <= n_last;
            r_init   <= n_init;
            r_uninit <= n_uninit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.eval) begin
            r_neg     <= w_delta[DATA_W];
            r_absd    <= w_absd[DATA_W-1:0];
            r_elapsed <= w_elapsed;
        end
        if (i_cmd.mul) begin
            r_rem <= w_prod[2*DATA_W-1:DATA_W];
            r_quo <= w_prod[DATA_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? DATA_W'(w_trial - {1'b0, r_resp}) : w_trial[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_qbit};
        end
        if (i_cmd.load_out) begin
            r_out.current_value <= r_uninit ? '0 : r_follow;
            r_out.ready_res     <= r_uninit ? 1'b0 : r_init;
        end
    end

    assign o_item = r_out;

endmodule
